// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the rotation stream cipher unit.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int CHAR_W      = 8;
    localparam int SEED_W      = 16;
    localparam int GEN_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int POS_W       = 7;

    localparam logic [GEN_W-1:0]  GEN_RESET  = 17'd1;
    localparam logic [7:0]        MULTIPLIER = 8'd75;
    localparam logic [17:0]       MODULUS    = 18'd65537;
    localparam logic [POS_W-1:0]  RING_SIZE  = 7'd96;
    localparam logic [CHAR_W-1:0] RING_BASE  = 8'd32;
    localparam logic [CHAR_W-1:0] RING_TOP   = 8'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_SEED     = 2'd0,
        REG_DECRYPT_MODE = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [SEED_W-1:0] seed;
    } t_gen_ctrl;

endpackage

// ===== rtl/prng_rotation_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher_unit
// Byte stream cipher: Lehmer key stream, rotation within the printable ring.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | i_valid, o_stall, i_char_in           | in
//  output   | o_valid, i_stall, o_char_out          | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data     | in
//
//  one beat per cycle unless stalled; input stage, then output register
//  the generator step (constant multiply and fold) sits in the input stage,
//  the mod 96 and ring rotation feed the output register
//  each stage holds under stall, so the input side keeps taking beats while
//  a result waits as long as the first stage is free
//  synchronous active-low reset: seed 1, encrypt mode, both stages empty
// ----------------------------------------------------------------------------
module prng_rotation_stream_cipher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [prc_pkg::CHAR_W-1:0]       i_char_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [prc_pkg::CHAR_W-1:0]       o_char_out,
    input  logic                             i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import prc_pkg::*;

    logic              r_decrypt_mode;
    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_char;
    logic [GEN_W-1:0]  r_s1_key;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;

    logic              w_s2_ready;
    logic              w_in_acc;
    logic              w_s1_move;
    t_gen_ctrl         w_gen_ctrl;
    logic [GEN_W-1:0]  w_next_key;
    logic [CHAR_W-1:0] w_rot_char;

    assign w_s2_ready = !r_out_valid || !i_stall;
    assign o_stall    = r_s1_valid && !w_s2_ready;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_s1_move  = r_s1_valid && w_s2_ready;

    assign w_gen_ctrl.load = i_cfg_we && (i_cfg_index == REG_KEY_SEED);
    assign w_gen_ctrl.step = w_in_acc;
    assign w_gen_ctrl.seed = i_cfg_data[SEED_W-1:0];

    prc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_gen_ctrl),
        .o_key   (w_next_key)
    );

    prc_rotate u_rotate (
        .i_char     (r_s1_char),
        .i_key      (r_s1_key),
        .i_backward (r_decrypt_mode),
        .o_char     (w_rot_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt_mode <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_DECRYPT_MODE)) begin
                r_decrypt_mode <= i_cfg_data[0];
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_char <= i_char_in;
            r_s1_key  <= w_next_key;
        end
        if (w_s1_move) begin
            r_out_char <= w_rot_char;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char_out = r_out_char;

endmodule

// ===== rtl/prc_keygen.sv =====
// ----------------------------------------------------------------------------
// prc_keygen
// Lehmer generator modulo 65537, multiplier 75; one step per accepted beat.
// ----------------------------------------------------------------------------
module prc_keygen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prc_pkg::t_gen_ctrl            i_ctrl,
    output logic [prc_pkg::GEN_W-1:0]     o_key
);
    import prc_pkg::*;

    logic [GEN_W-1:0] r_gen;
    logic [GEN_W-1:0] n_gen;
    logic [23:0]      w_prod;
    logic [17:0]      w_lo;
    logic [17:0]      w_hi;
    logic [17:0]      w_red;

    // 75*x fits in 23 bits for x up to 65536
    assign w_prod = {7'd0, r_gen} * {16'd0, MULTIPLIER};
    assign w_lo   = {2'd0, w_prod[15:0]};
    assign w_hi   = {10'd0, w_prod[23:16]};

    // 2^16 == -1 mod 65537, so fold high part by subtraction
    always_comb begin
        if (w_lo >= w_hi) begin
            w_red = w_lo - w_hi;
        end else begin
            w_red = w_lo + MODULUS - w_hi;
        end
    end

    assign o_key = w_red[GEN_W-1:0];

    always_comb begin
        n_gen = r_gen;
        if (i_ctrl.load) begin
            n_gen = {1'b0, i_ctrl.seed};
        end else if (i_ctrl.step) begin
            n_gen = o_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_RESET;
        end else begin
            r_gen <= n_gen;
        end
    end

endmodule

// ===== rtl/prc_rotate.sv =====
// ----------------------------------------------------------------------------
// prc_rotate
// Rotates a printable byte within the 96-symbol ring by key mod 96, forward or
// backward; bytes outside the ring pass unchanged.
module prc_rotate (
    input  logic [prc_pkg::CHAR_W-1:0] i_char,
    input  logic [prc_pkg::GEN_W-1:0]  i_key,
    input  logic                       i_backward,
    output logic [prc_pkg::CHAR_W-1:0] o_char
);
    import prc_pkg::*;

    logic [4:0]       w_dsum;
    logic [2:0]       w_fold1;
    logic [2:0]       w_fold2;
    logic [1:0]       w_mod3;
    logic [POS_W-1:0] w_shift;
    logic [POS_W-1:0] w_pos;
    logic [POS_W:0]   w_fwd;
    logic [POS_W-1:0] w_res;
    logic             w_in_ring;

    function automatic logic [POS_W-1:0] w_char_off(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = c - RING_BASE;
        return d[POS_W-1:0];
    endfunction

    // key mod 96 = ((key >> 5) mod 3) * 32 + key[4:0]
    // base-4 digits of key >> 5 summed, then folded, give the mod 3 value
    assign w_dsum = {3'd0, i_key[6:5]}   + {3'd0, i_key[8:7]}
                  + {3'd0, i_key[10:9]}  + {3'd0, i_key[12:11]}
                  + {3'd0, i_key[14:13]} + {3'd0, i_key[16:15]};
    assign w_fold1 = {2'd0, w_dsum[4]} + {1'b0, w_dsum[3:2]} + {1'b0, w_dsum[1:0]};
    assign w_fold2 = {2'd0, w_fold1[2]} + {1'b0, w_fold1[1:0]};

    always_comb begin
        case (w_fold2)
            3'd3:    w_mod3 = 2'd0;
            3'd4:    w_mod3 = 2'd1;
            default: w_mod3 = w_fold2[1:0];
        endcase
    end

    assign w_shift   = {w_mod3, i_key[4:0]};
    assign w_in_ring = (i_char >= RING_BASE) && (i_char <= RING_TOP);
    assign w_pos     = w_char_off(i_char);
    assign w_fwd     = {1'b0, w_pos} + {1'b0, w_shift};

    always_comb begin
        if (i_backward) begin
            if (w_pos >= w_shift) begin
                w_res = w_pos - w_shift;
            end else begin
                w_res = w_pos + RING_SIZE - w_shift;
            end
        end else begin
            if (w_fwd >= {1'b0, RING_SIZE}) begin
                w_res = w_fwd[POS_W-1:0] - RING_SIZE;
            end else begin
                w_res = w_fwd[POS_W-1:0];
            end
        end
    end

    assign o_char = w_in_ring ? ({1'b0, w_res} + RING_BASE) : i_char;

endmodule

// ===== bench/prc_cipher_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prc_cipher_checker
// Follows the config port and both byte channels of the cipher unit. It keeps
// its own Lehmer key stream and mode, predicts each output byte as the input
// beat is taken, and checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module prc_cipher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [prc_pkg::CHAR_W-1:0]     i_char_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [prc_pkg::CHAR_W-1:0]     i_char_out,
    input  logic                           i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import prc_pkg::*;

    logic              decrypt_q = 1'b0;
    logic [GEN_W-1:0]  keystream_q = GEN_RESET;
    logic [CHAR_W-1:0] expected_chars[$];
    int                error_count = 0;
    int                pending_count = 0;
    int                checked_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_checked = checked_count;

    // x -> 75 * x mod 65537, folding the bits above 16 back in
    function automatic logic [GEN_W-1:0] lehmer_next(input logic [GEN_W-1:0] x);
        logic [23:0] prod;
        logic [15:0] lo;
        logic [7:0]  hi;
        logic [17:0] diff;
        prod = 24'(x) * 24'(MULTIPLIER);
        lo   = prod[15:0];
        hi   = prod[23:16];
        if (lo >= 16'(hi)) begin
            diff = 18'(lo) - 18'(hi);
        end else begin
            diff = 18'(lo) + MODULUS - 18'(hi);
        end
        return diff[GEN_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] cipher_byte(input logic [CHAR_W-1:0] c,
                                                      input logic [GEN_W-1:0]  key,
                                                      input logic              backward);
        logic [POS_W-1:0] shift;
        logic [POS_W-1:0] pos;
        logic [7:0]       sum;
        if (c < RING_BASE || c > RING_TOP) begin
            return c;
        end
        shift = POS_W'(key % GEN_W'(RING_SIZE));
        pos   = POS_W'(c - RING_BASE);
        if (backward) begin
            sum = 8'(pos) + 8'(RING_SIZE) - 8'(shift);
        end else begin
            sum = 8'(pos) + 8'(shift);
        end
        if (sum >= 8'(RING_SIZE)) begin
            sum = sum - 8'(RING_SIZE);
        end
        return sum + RING_BASE;
    endfunction

    always @(posedge i_clk) begin : track
        logic [CHAR_W-1:0] want;
        if (!i_rst_n) begin
            decrypt_q   = 1'b0;
            keystream_q = GEN_RESET;
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_SEED:     keystream_q = GEN_W'(i_cfg_data);
                    REG_DECRYPT_MODE: decrypt_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            // key advances before the byte is rotated, on every beat
            if (i_in_valid && !i_in_stall) begin
                keystream_q = lehmer_next(keystream_q);
                expected_chars.push_back(cipher_byte(i_char_in, keystream_q, decrypt_q));
            end
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: result beat with nothing expected: expected none, actual 0x%02h",
                             $time, i_char_out);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_char_out !== want) begin
                        error_count++;
                        $display("%0t: char_out mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want, i_char_out);
                    end
                end
            end
        end
        pending_count = expected_chars.size();
    end

endmodule

// ===== bench/tb_prng_rotation_stream_cipher_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prng_rotation_stream_cipher_unit
// Drives byte beats and register writes into the cipher unit with random
// input gaps and receiver stalls; the checker beside the block predicts and
// compares every result. Covers seed extremes, both modes, control, ring and
// high bytes, spare register indexes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_prng_rotation_stream_cipher_unit;
    import prc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [CHAR_W-1:0]     i_char_in;
    logic                  o_valid;
    logic                  i_stall;
    logic [CHAR_W-1:0]     o_char_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors;
    int pending;
    int checked;
    int sent = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    prng_rotation_stream_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_in   (i_char_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_out  (o_char_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    prc_cipher_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_char_in   (i_char_in),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_char_out  (o_char_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) begin
                    i_stall = 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall = idle_on && ($urandom_range(0, 99) < 33);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_char_in = c;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return CHAR_W'($urandom_range(RING_BASE, RING_TOP));
        if (roll < 75) return CHAR_W'($urandom_range(0, RING_BASE - 1));
        if (roll < 90) return CHAR_W'($urandom_range(RING_TOP + 1, 255));
        return CHAR_W'($urandom);
    endfunction

    task automatic run_phase(input int count, input logic [SEED_W-1:0] seed,
                             input logic mode, input bit with_hold);
        int n;
        write_reg(REG_KEY_SEED, seed);
        write_reg(REG_DECRYPT_MODE, {15'($urandom), mode});
        for (n = 0; n < count; n++) begin
            if (with_hold && n == 40) hold_req = 1'b1;
            send_char(pick_char());
        end
    endtask

    initial begin : stimulus
        logic [CHAR_W-1:0] boundary_chars[9];
        logic [SEED_W-1:0] seed;
        int ph;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_char_in   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_KEY_SEED;
        i_cfg_data  = '0;
        boundary_chars = '{8'd0, 8'd31, 8'd32, 8'd33, 8'd126, 8'd127, 8'd128, 8'd255, 8'h41};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: seed 1, encrypt
        foreach (boundary_chars[k]) send_char(boundary_chars[k]);

        // zero seed keeps the key at zero; mode bit taken from bit 0 only
        write_reg(REG_KEY_SEED, 16'h0000);
        write_reg(REG_DECRYPT_MODE, 16'hFFFF);
        send_char(8'd32);
        send_char(8'd127);
        send_char(8'd90);
        send_char(8'd5);
        send_char(8'd200);

        // spare indexes must not touch anything
        write_reg(REG_SPARE_2, 16'h1234);
        write_reg(REG_SPARE_3, 16'hFFFF);
        send_char(8'd64);

        write_reg(REG_KEY_SEED, 16'hFFFF);
        write_reg(REG_DECRYPT_MODE, 16'hFFFE);
        send_char(8'd32);
        send_char(8'd127);
        send_char(8'd64);
        write_reg(REG_DECRYPT_MODE, 16'h0001);
        send_char(8'd32);
        send_char(8'd127);
        send_char(8'd100);
        send_char(8'd0);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       seed = 16'hFFFF;
                3:       seed = 16'h0001;
                default: seed = SEED_W'($urandom);
            endcase
            idle_on = (ph != 1);
            run_phase(PHASE_ITEMS, seed, (ph == 4) ? 1'($urandom) : 1'(ph), ph == 2);
        end
        idle_on = 1'b1;
        run_phase(40, 16'h0000, 1'b0, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d char beats, %0d result beats checked, %0d register writes",
                 sent, checked, cfg_writes);
        $display("seeds 0, 1, 65535 and random; both modes; all byte classes; long hold-off");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
